@@ sv/sve_pkg.sv @@
// ----------------------------------------------------------------------------
// sve_pkg
// shared types and constants of the stack machine instruction executor
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int unsigned STACK_DEPTH    = 1024;
  localparam int unsigned REGISTER_COUNT = 6;
  localparam int unsigned DataW          = 32;
  localparam int unsigned IndexW         = 16;

  // opcodes, bits 31:24 of the instruction word
  typedef enum logic [7:0] {
    OP_END   = 8'd0,
    OP_MOVE  = 8'd1,
    OP_PUSHI = 8'd2,
    OP_PUSHR = 8'd3,
    OP_POPR  = 8'd4,
    OP_ADD   = 8'd5,
    OP_SUB   = 8'd6,
    OP_MUL   = 8'd7,
    OP_JUMP  = 8'd8,
    OP_JZ    = 8'd9,
    OP_PRINT = 8'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_END    = 3'd1,
    ST_BADOP  = 3'd2,
    ST_BADREG = 3'd3,
    ST_UNDER  = 3'd4,
    ST_OVER   = 3'd5
  } status_e;

endpackage

@@ sv/sve_instr_if.sv @@
// ----------------------------------------------------------------------------
// sve_instr_if
// instruction channel: instruction word and operand word with valid/ready
// ----------------------------------------------------------------------------
interface sve_instr_if;
  logic                        valid;
  logic                        ready;
  logic [sve_pkg::DataW-1:0]   instruction_word;
  logic [sve_pkg::DataW-1:0]   operand_value;

  modport source (output valid, output instruction_word, output operand_value, input ready);
  modport sink   (input valid, input instruction_word, input operand_value, output ready);
endinterface

@@ sv/sve_result_if.sv @@
// ----------------------------------------------------------------------------
// sve_result_if
// result channel: next index, print value, status and halt flag
// ----------------------------------------------------------------------------
interface sve_result_if;
  logic                             valid;
  logic                             ready;
  logic [sve_pkg::IndexW-1:0]       next_index;
  logic                             print_valid;
  logic signed [sve_pkg::DataW-1:0] print_value;
  logic [2:0]                       status;
  logic                             halted;

  modport source (output valid, output next_index, output print_valid, output print_value,
                  output status, output halted, input ready);
  modport sink   (input valid, input next_index, input print_valid, input print_value,
                  input status, input halted, output ready);
endinterface

@@ sv/stack_vm_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor
// executes one stack machine instruction per accepted word
// ----------------------------------------------------------------------------
// usage
//   instr_i  : instruction word (opcode, dest, source) plus operand word
//   result_o : next index, optional printed value, status and halt flag
//   every accepted instruction word gives exactly one result word
// pipeline and throughput
//   a word lands in the input register at its accept edge and executes once
//   the output slot is free; its result is in the output register at the
//   next edge, where result valid is set; one instruction per cycle is
//   sustained while each result is taken as soon as it is offered
//   the top two stack entries live in flops; the ram keeps every entry and
//   its registered read port always holds the third entry, so a binary op
//   or pop never waits on the ram
// reset
//   registers, stack count, program index and halt flag go to zero; stack
//   ram contents are undefined and are only read after being pushed
// stall
//   a held result blocks execution; the input register then fills and
//   instr_i.ready drops, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor #(
  parameter int unsigned STACK_DEPTH    = sve_pkg::STACK_DEPTH,
  parameter int unsigned REGISTER_COUNT = sve_pkg::REGISTER_COUNT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sve_instr_if.sink      instr_i,
  sve_result_if.source   result_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH);
  localparam int unsigned RegW = $clog2(REGISTER_COUNT);
  localparam int unsigned DW   = sve_pkg::DataW;
  localparam int unsigned IW   = sve_pkg::IndexW;

  // input register
  logic          in_vld_q;
  logic [DW-1:0] in_word_q;
  logic [DW-1:0] in_opnd_q;

  // machine state
  logic [DW-1:0]   regs_q [REGISTER_COUNT];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IW-1:0]   pc_q, pc_d;
  logic            halt_q, halt_d;
  logic [DW-1:0]   top_q, top_d;       // entry cnt-1
  logic [DW-1:0]   second_q, second_d; // entry cnt-2
  logic [DW-1:0]   third;              // entry cnt-3, from ram read port

  // output register
  logic                 out_vld_q;
  logic [IW-1:0]        out_idx_q, out_idx_d;
  logic                 out_pv_q, out_pv_d;
  logic [DW-1:0]        out_pval_q, out_pval_d;
  sve_pkg::status_e     out_st_q, out_st_d;

  // decode
  logic [7:0]   op_byte, dst_byte, src_byte;
  logic         dst_ok, src_ok, can_push;
  logic [DW-1:0] reg_rd;
  logic         exec;

  // register file write
  logic            reg_we;
  logic [RegW-1:0] reg_waddr;
  logic [DW-1:0]   reg_wdata;

  // stack ram ports
  logic            ram_we;
  logic [CntW-1:0] ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [CntW-1:0] ram_raddr;

  assign op_byte  = in_word_q[31:24];
  assign dst_byte = in_word_q[23:16];
  assign src_byte = in_word_q[15:8];

  assign dst_ok   = {1'b0, dst_byte} < 9'(REGISTER_COUNT);
  assign src_ok   = {1'b0, src_byte} < 9'(REGISTER_COUNT);
  assign can_push = cnt_q < CntW'(STACK_DEPTH - 1);

  // single register read port: push register reads dest, move reads source
  assign reg_rd = (op_byte == sve_pkg::OP_PUSHR) ? regs_q[dst_byte[RegW-1:0]]
                                                 : regs_q[src_byte[RegW-1:0]];

  // execute when an instruction waits and the output slot is free
  assign exec          = in_vld_q && (!out_vld_q || result_o.ready);
  assign instr_i.ready = !in_vld_q || exec;

  always_comb begin
    cnt_d      = cnt_q;
    pc_d       = pc_q;
    halt_d     = halt_q;
    top_d      = top_q;
    second_d   = second_q;
    out_idx_d  = pc_q;
    out_pv_d   = 1'b0;
    out_pval_d = '0;
    out_st_d   = sve_pkg::ST_OK;
    reg_we     = 1'b0;
    reg_waddr  = dst_byte[RegW-1:0];
    reg_wdata  = top_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = in_opnd_q;

    if (exec && !halt_q) begin
      pc_d = pc_q + IW'(1);
      case (op_byte)
        sve_pkg::OP_END: begin
          out_st_d = sve_pkg::ST_END;
        end
        sve_pkg::OP_MOVE: begin
          if (!dst_ok || (src_byte != 8'd0 && !src_ok)) begin
            out_st_d = sve_pkg::ST_BADREG;
          end else begin
            reg_we    = 1'b1;
            reg_wdata = (src_byte == 8'd0) ? in_opnd_q : reg_rd;
          end
        end
        sve_pkg::OP_PUSHI, sve_pkg::OP_PUSHR: begin
          if (op_byte == sve_pkg::OP_PUSHR && !dst_ok) begin
            out_st_d = sve_pkg::ST_BADREG;
          end else if (!can_push) begin
            out_st_d = sve_pkg::ST_OVER;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = (op_byte == sve_pkg::OP_PUSHR) ? reg_rd : in_opnd_q;
            top_d     = ram_wdata;
            second_d  = top_q;
            cnt_d     = cnt_q + CntW'(1);
          end
        end
        sve_pkg::OP_POPR: begin
          if (!dst_ok) begin
            out_st_d = sve_pkg::ST_BADREG;
          end else if (cnt_q == '0) begin
            out_st_d = sve_pkg::ST_UNDER;
          end else begin
            reg_we   = 1'b1;
            top_d    = second_q;
            second_d = third;
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        sve_pkg::OP_ADD, sve_pkg::OP_SUB, sve_pkg::OP_MUL: begin
          if (cnt_q < CntW'(2)) begin
            out_st_d = sve_pkg::ST_UNDER;
          end else begin
            // a is the lower entry, b the top
            case (op_byte)
              sve_pkg::OP_ADD: ram_wdata = second_q + top_q;
              sve_pkg::OP_SUB: ram_wdata = second_q - top_q;
              default:         ram_wdata = DW'(second_q * top_q);
            endcase
            ram_we    = 1'b1;
            ram_waddr = cnt_q - CntW'(2);
            top_d     = ram_wdata;
            second_d  = third;
            cnt_d     = cnt_q - CntW'(1);
          end
        end
        sve_pkg::OP_JUMP: begin
          pc_d = in_opnd_q[IW-1:0];
        end
        sve_pkg::OP_JZ, sve_pkg::OP_PRINT: begin
          if (cnt_q == '0) begin
            out_st_d = sve_pkg::ST_UNDER;
          end else begin
            top_d    = second_q;
            second_d = third;
            cnt_d    = cnt_q - CntW'(1);
            if (op_byte == sve_pkg::OP_PRINT) begin
              out_pv_d   = 1'b1;
              out_pval_d = top_q;
            end else if (top_q == '0) begin
              pc_d = in_opnd_q[IW-1:0];
            end
          end
        end
        default: begin
          out_st_d = sve_pkg::ST_BADOP;
        end
      endcase
      if (out_st_d != sve_pkg::ST_OK) begin
        halt_d = 1'b1;
      end
      out_idx_d = pc_d;
    end
  end

  // keep the read port on the entry below the new second
  assign ram_raddr = cnt_d - CntW'(3);

  sve_ram #(
    .Width (DW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (third)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
    end else begin
      if (instr_i.ready) begin
        in_vld_q <= instr_i.valid;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      cnt_q  <= cnt_d;
      pc_q   <= pc_d;
      halt_q <= halt_d;
    end
  end

  // register file, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else if (reg_we) begin
      regs_q[reg_waddr] <= reg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (instr_i.valid && instr_i.ready) begin
      in_word_q <= instr_i.instruction_word;
      in_opnd_q <= instr_i.operand_value;
    end
    top_q    <= top_d;
    second_q <= second_d;
    if (exec) begin
      out_idx_q  <= out_idx_d;
      out_pv_q   <= out_pv_d;
      out_pval_q <= out_pval_d;
      out_st_q   <= out_st_d;
    end
  end

  // halted flag of a result equals the flag after its instruction, which is
  // the live flag while that result is held
  assign result_o.valid       = out_vld_q;
  assign result_o.next_index  = out_idx_q;
  assign result_o.print_valid = out_pv_q;
  assign result_o.print_value = $signed(out_pval_q);
  assign result_o.status      = out_st_q;
  assign result_o.halted      = halt_q;

endmodule

@@ sv/sve_ram.sv @@
// ----------------------------------------------------------------------------
// sve_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sve_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
